/* rtl/core/bada_pkg.sv */
package bada_pkg;
  localparam int unsigned SumW = 16;
  localparam int unsigned CntW = 9;
  localparam int unsigned MAX_TARGET_WIDTH = 256;
  localparam int unsigned MAX_FACTOR = 16;
  localparam int unsigned MAX_COMPONENTS = 4;

  typedef enum logic [4:0] {
    REG_SW = 5'd0,
    REG_SH = 5'd1,
    REG_TW = 5'd2,
    REG_TH = 5'd3,
    REG_NC = 5'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RMW   = 4'b0100,
    ST_DIV   = 4'b1000
  } state_t;
endpackage

/* rtl/core/box_area_average_downscale_unit.sv */
// channel  | direction | content
// s_axis   | in        | tdata: comp0..comp3, one grid position per request
// m_axis   | out       | tdata: avg0..avg3, tlast: frame_end, tuser: config_error
// apb      | in        | source/target sizes, component count
// a position takes two steps: acceptance (sums memory read), then add and write
// back, so no request is taken before the last one is written back; a block's
// last position then goes through the bit-serial count divider before its
// result appears. after reset and after each write to a config register the
// scan restarts at frame start and both memories are swept with s_axis_tready low.
// an error result appears in the cycle after its request; s_axis_tready stays low
// while a result waits, and output stalls hold the result register.
module box_area_average_downscale_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // comp0, comp1, comp2, comp3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // avg0, avg1, avg2, avg3
  output logic        m_axis_tlast,  // frame_end
  output logic        m_axis_tuser,  // config_error
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bada_pkg::*;

  localparam int unsigned ColW = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
  localparam int unsigned FW   = $clog2(MAX_FACTOR + 1);
  localparam int unsigned BW   = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int unsigned DepthS = MAX_TARGET_WIDTH;

  // config registers
  logic [12:0] source_width, source_height, target_height;
  logic [8:0]  target_width;
  logic [2:0]  num_components;
  logic        cfg_bad;
  logic [FW-1:0] scale_factor;

  logic wr_en;
  logic cfg_wr;
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign cfg_wr = wr_en && (paddr[4:2] <= 3'(REG_NC));

  // register read back
  always_comb begin
    prdata = '0;
    case (reg_idx_t'(paddr[4:2]))
      REG_SW: prdata = {19'd0, source_width};
      REG_SH: prdata = {19'd0, source_height};
      REG_TW: prdata = {23'd0, target_width};
      REG_TH: prdata = {19'd0, target_height};
      REG_NC: prdata = {29'd0, num_components};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width <= 13'd1;
      source_height <= 13'd1;
      target_width <= 9'd1;
      target_height <= 13'd1;
      num_components <= 3'd4;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[4:2]))
        REG_SW: source_width <= pwdata[12:0];
        REG_SH: source_height <= pwdata[12:0];
        REG_TW: target_width <= pwdata[8:0];
        REG_TH: target_height <= pwdata[12:0];
        REG_NC: num_components <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // factor: smallest f with f*tw >= sw and f*th >= sh, searched while clearing
  logic [FW-1:0] fsearch;
  logic          fdone;
  logic [13+FW-1:0] fw_prod, fh_prod;
  assign fw_prod = fsearch * target_width;
  assign fh_prod = fsearch * target_height;

  // state
  state_t state;
  logic [ColW-1:0] clr_addr;
  logic [11:0] grid_column, grid_row;
  logic [BW-1:0] col_in_blk, row_in_blk;
  logic [ColW-1:0] out_col;

  // memories
  logic [4*SumW-1:0] sums_mem [DepthS];
  logic [CntW-1:0]   cnt_mem  [DepthS];
  logic [4*SumW-1:0] sums_rd;
  logic [CntW-1:0]   cnt_rd;
  logic              sums_we;
  logic [4*SumW-1:0] sums_wd;
  logic [CntW-1:0]   cnt_wd;
  logic [ColW-1:0]   mem_waddr;

  always_ff @(posedge clk) begin
    if (sums_we) begin
      sums_mem[mem_waddr] <= sums_wd;
      cnt_mem[mem_waddr] <= cnt_wd;
    end
    sums_rd <= sums_mem[out_col];
    cnt_rd <= cnt_mem[out_col];
  end

  // captured request
  logic [31:0] pix;
  logic        first_pos, last_pos, in_src;
  logic [12+FW-1:0] src_row;
  assign src_row = grid_row * scale_factor + {{(12+FW-BW){1'b0}}, row_in_blk};
  assign first_pos = (col_in_blk == '0) && (row_in_blk == '0);
  assign last_pos = ({{(FW-BW){1'b0}}, col_in_blk} == scale_factor - 1'b1) &&
                    ({{(FW-BW){1'b0}}, row_in_blk} == scale_factor - 1'b1);
  assign in_src = ({1'b0, grid_column} < source_width) &&
                  (src_row < {{(FW-1){1'b0}}, source_height});

  // read-modify-write data
  logic [4*SumW-1:0] acc;
  logic [CntW-1:0]   cnt_new;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc[k*SumW +: SumW] = first_pos ? '0 : sums_rd[k*SumW +: SumW];
      if (in_src && k < int'(num_components))
        acc[k*SumW +: SumW] = acc[k*SumW +: SumW] + {8'd0, pix[k*8 +: 8]};
    end
    cnt_new = (first_pos ? '0 : cnt_rd) + (in_src ? CntW'(1) : CntW'(0));
  end

  always_comb begin
    sums_we = (state == ST_CLEAR) || (state == ST_RMW);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : out_col;
    sums_wd = (state == ST_CLEAR) ? '0 : acc;
    cnt_wd = (state == ST_CLEAR) ? '0 : cnt_new;
  end

  // divider: four restoring quotients of 16/9 bits, one bit per cycle
  logic [4*SumW-1:0] dq;
  logic [4*CntW-1:0] drem;
  logic [CntW-1:0]   dcnt;
  logic [4:0]        dstep;
  logic              dframe;
  logic [4*SumW-1:0] dq_next;
  logic [4*CntW-1:0] drem_next;
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [CntW:0] t;
      t = {drem[k*CntW +: CntW], dq[k*SumW + SumW - 1]};
      dq_next[k*SumW +: SumW] = {dq[k*SumW +: SumW-1], 1'b0};
      if (t >= {1'b0, dcnt}) begin
        t = t - {1'b0, dcnt};
        dq_next[k*SumW] = 1'b1;
      end
      drem_next[k*CntW +: CntW] = t[CntW-1:0];
    end
  end

  logic in_acc, out_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;

  // scan advance
  logic [11:0] gc_next, gr_next;
  logic [BW-1:0] cb_next, rb_next;
  logic [ColW-1:0] oc_next;
  always_comb begin
    gc_next = grid_column + 1'b1;
    gr_next = grid_row;
    cb_next = col_in_blk + 1'b1;
    rb_next = row_in_blk;
    oc_next = out_col;
    if ({{(FW-BW){1'b0}}, col_in_blk} + 1'b1 >= scale_factor) begin
      cb_next = '0;
      oc_next = out_col + 1'b1;
      if ({{(9-ColW){1'b0}}, out_col} + 1'b1 >= target_width) begin
        oc_next = '0;
        gc_next = '0;
        rb_next = row_in_blk + 1'b1;
        if ({{(FW-BW){1'b0}}, row_in_blk} + 1'b1 >= scale_factor) begin
          rb_next = '0;
          gr_next = ({1'b0, grid_row} + 1'b1 >= target_height) ? '0 : grid_row + 1'b1;
        end
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      fsearch <= FW'(1);
      fdone <= 1'b0;
      cfg_bad <= 1'b1;
      scale_factor <= FW'(1);
      grid_column <= '0;
      grid_row <= '0;
      col_in_blk <= '0;
      row_in_blk <= '0;
      out_col <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_acc) m_axis_tvalid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (!fdone) begin
            if (fw_prod >= {{FW{1'b0}}, source_width} &&
                fh_prod >= {{FW{1'b0}}, source_height}) begin
              fdone <= 1'b1;
              scale_factor <= fsearch;
              cfg_bad <= (source_width == 0) || (source_height == 0) ||
                         (target_width == 0) || (target_height == 0) ||
                         ({4'd0, target_width} > source_width) ||
                         (target_height > source_height) ||
                         (32'(target_width) > MAX_TARGET_WIDTH) ||
                         (num_components == 0) ||
                         (32'(num_components) > MAX_COMPONENTS);
            end else if (32'(fsearch) >= MAX_FACTOR) begin
              fdone <= 1'b1;
              cfg_bad <= 1'b1;
            end else begin
              fsearch <= fsearch + 1'b1;
            end
          end
          if (&clr_addr && fdone) state <= ST_IDLE;
          else if (&clr_addr) clr_addr <= clr_addr;
        end
        ST_IDLE: begin
          if (in_acc) begin
            pix <= s_axis_tdata;
            if (cfg_bad) begin
              m_axis_tvalid <= 1'b1;
              m_axis_tdata <= '0;
              m_axis_tlast <= 1'b0;
              m_axis_tuser <= 1'b1;
            end else begin
              state <= ST_RMW;
            end
          end
        end
        ST_RMW: begin
          grid_column <= gc_next;
          grid_row <= gr_next;
          col_in_blk <= cb_next;
          row_in_blk <= rb_next;
          out_col <= oc_next;
          if (last_pos) begin
            dq <= acc;
            drem <= '0;
            dcnt <= cnt_new;
            dstep <= '0;
            dframe <= ({1'b0, out_col} == target_width - 1'b1) &&
                      ({1'b0, grid_row} == target_height - 1'b1);
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          dq <= dq_next;
          drem <= drem_next;
          dstep <= dstep + 1'b1;
          if (dstep == 5'(SumW - 1)) begin
            state <= ST_IDLE;
            m_axis_tvalid <= 1'b1;
            m_axis_tlast <= dframe;
            m_axis_tuser <= 1'b0;
            for (int k = 0; k < 4; k++)
              m_axis_tdata[k*8 +: 8] <= (dcnt == '0 || k >= int'(num_components)) ? 8'd0 :
                                        dq_next[k*SumW +: 8];
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("request taken while busy");
  a_err_tuser: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("error result carries data");
  a_hold: assert property (@(posedge clk) disable iff (rst || cfg_wr)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped");
  a_err_no_rmw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW) |-> !cfg_bad) else $error("rmw with bad config");
`endif
endmodule

/* verif/tb_box_area_average_downscale_unit.sv */
`timescale 1ns / 100ps

import bada_pkg::*;

typedef struct {
  logic [7:0] avg [4];
  logic       frame_end;
  logic       config_error;
} out_pixel_t;

// area-average predictor and store of expected output pixels
class downscale_scoreboard;
  int unsigned src_w, src_h, tgt_w, tgt_h, n_comp;
  int unsigned comp_sum [1024];
  int unsigned px_count [256];
  int unsigned col, grow, cib, rib, ocol, factor;
  bit          bad_cfg;
  out_pixel_t  pending [$];
  int          errors;

  function new();
    src_w = 1; src_h = 1; tgt_w = 1; tgt_h = 1; n_comp = 4;
    errors = 0;
    restart();
  endfunction

  // scan back to frame start, validate sizes and derive the block edge
  function void restart();
    int unsigned fx, fy;
    col = 0; grow = 0; cib = 0; rib = 0; ocol = 0; factor = 1;
    bad_cfg = 1;
    if (src_w == 0 || src_h == 0 || tgt_w == 0 || tgt_h == 0) return;
    if (tgt_w > src_w || tgt_h > src_h || tgt_w > 256) return;
    if (n_comp == 0 || n_comp > 4) return;
    fx = (src_w + tgt_w - 1) / tgt_w;
    fy = (src_h + tgt_h - 1) / tgt_h;
    if ((fx > fy ? fx : fy) > 16) return;
    factor = fx > fy ? fx : fy;
    bad_cfg = 0;
  endfunction

  function void write_reg(reg_idx_t idx, int unsigned val);
    case (idx)
      REG_SW: src_w = val & 32'h1fff;
      REG_SH: src_h = val & 32'h1fff;
      REG_TW: tgt_w = val & 32'h1ff;
      REG_TH: tgt_h = val & 32'h1fff;
      REG_NC: n_comp = val & 32'h7;
      default: ;
    endcase
    restart();
  endfunction

  // accumulate one accepted grid position, queue a pixel on block end
  function void note_request(logic [31:0] data);
    out_pixel_t  px;
    int unsigned base;
    if (bad_cfg) begin
      for (int k = 0; k < 4; k++) px.avg[k] = '0;
      px.frame_end = 0;
      px.config_error = 1;
      pending.push_back(px);
      return;
    end
    base = ocol * 4;
    if (cib == 0 && rib == 0) begin
      for (int k = 0; k < 4; k++) comp_sum[base + k] = 0;
      px_count[ocol] = 0;
    end
    if (col < src_w && grow * factor + rib < src_h) begin
      for (int k = 0; k < 4; k++)
        if (k < n_comp) comp_sum[base + k] += data[8*k +: 8];
      px_count[ocol] += 1;
    end
    if (cib == factor - 1 && rib == factor - 1) begin
      for (int k = 0; k < 4; k++)
        px.avg[k] = (px_count[ocol] != 0 && k < n_comp) ?
                    8'(comp_sum[base + k] / px_count[ocol]) : 8'd0;
      px.frame_end = (ocol == tgt_w - 1 && grow == tgt_h - 1);
      px.config_error = 0;
      pending.push_back(px);
    end
    cib++;
    col++;
    if (cib >= factor) begin
      cib = 0;
      ocol++;
      if (ocol >= tgt_w) begin
        ocol = 0;
        col = 0;
        rib++;
        if (rib >= factor) begin
          rib = 0;
          grow++;
          if (grow >= tgt_h) grow = 0;
        end
      end
    end
  endfunction

  function void check_result(logic [31:0] data, logic last, logic user);
    out_pixel_t px;
    if (pending.size() == 0) begin
      $error("unexpected output pixel data=%h last=%b user=%b", data, last, user);
      errors++;
      return;
    end
    px = pending.pop_front();
    for (int k = 0; k < 4; k++)
      if (data[8*k +: 8] !== px.avg[k]) begin
        $error("avg%0d expected %0d actual %0d", k, px.avg[k], data[8*k +: 8]);
        errors++;
      end
    if (last !== px.frame_end) begin
      $error("frame_end expected %0d actual %0d", px.frame_end, last);
      errors++;
    end
    if (user !== px.config_error) begin
      $error("config_error expected %0d actual %0d", px.config_error, user);
      errors++;
    end
  endfunction
endclass

module tb_box_area_average_downscale_unit;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // comp0, comp1, comp2, comp3
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;       // avg0, avg1, avg2, avg3
  logic        m_axis_tlast;       // frame_end
  logic        m_axis_tuser;       // config_error
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  downscale_scoreboard sb = new();
  bit hold_output = 0;
  bit no_idle = 0;
  int items_sent = 0;

  box_area_average_downscale_unit DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic write_reg(reg_idx_t idx, int unsigned val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic set_sizes(int unsigned sw, sh, tw, th, nc);
    write_reg(REG_SW, sw);
    write_reg(REG_SH, sh);
    write_reg(REG_TW, tw);
    write_reg(REG_TH, th);
    write_reg(REG_NC, nc);
  endtask

  // one request on the input stream; valid stays high when no gap follows
  task automatic send_pos(logic [31:0] data);
    s_axis_tvalid <= 1;
    s_axis_tdata <= data;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(data);
    items_sent++;
  endtask

  task automatic send_burst(int n, bit directed_pattern);
    int gap;
    logic [31:0] d;
    for (int i = 0; i < n; i++) begin
      if (directed_pattern)
        case (i % 4)
          0: d = 32'h0000_0000;
          1: d = 32'hffff_ffff;
          2: d = 32'haaaa_5555;
          default: d = $urandom;
        endcase
      else
        d = $urandom;
      send_pos(d);
      gap = pick_gap();
      if (gap > 0 || i == n - 1) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait for every expected pixel, then let any last position drain
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // output side with random stalls and an occasional long hold-off
  always begin
    if (hold_output) begin
      m_axis_tready <= 0;
      repeat (300) @(posedge clk);
      hold_output = 0;
    end
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 3) != 0);
    @(posedge clk);
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // watchdog on cycles with no transfer at all
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= 5000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sw, sh, tw, th, nc, fx, fy, f, n;
    repeat (2) @(posedge clk);
    rst <= 0;

    // reset sizes: one output pixel per position
    send_burst(4, 1);
    drain();

    // partial block on the right edge
    set_sizes(3, 2, 2, 1, 3);
    send_burst(8, 1);
    drain();

    // lower output row made of empty blocks
    set_sizes(4, 2, 2, 2, 1);
    send_burst(16, 1);
    drain();

    // invalid settings
    set_sizes(1, 1, 2, 1, 4);
    send_burst(2, 0);
    drain();
    set_sizes(4096, 4096, 1, 1, 4);
    send_burst(2, 0);
    drain();
    set_sizes(300, 1, 257, 1, 2);
    send_burst(2, 0);
    drain();
    set_sizes(4, 4, 2, 2, 0);
    send_burst(2, 0);
    drain();
    set_sizes(4, 4, 2, 2, 5);
    send_burst(2, 0);
    drain();
    set_sizes(0, 4, 2, 2, 4);
    send_burst(2, 0);
    drain();

    // widest target, tallest image; output held off while input keeps coming
    set_sizes(256, 4096, 256, 4096, 4);
    hold_output = 1;
    send_burst(300, 0);
    drain();

    // random small frames
    while (items_sent < 1700) begin
      sw = $urandom_range(1, 20);
      sh = $urandom_range(1, 12);
      tw = $urandom_range(1, sw < 6 ? sw : 6);
      th = $urandom_range(1, sh < 4 ? sh : 4);
      nc = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) tw = sw + 1;
      no_idle = ($urandom_range(0, 4) == 0);
      set_sizes(sw, sh, tw, th, nc);
      fx = (sw + tw - 1) / tw;
      fy = (sh + th - 1) / th;
      f = fx > fy ? fx : fy;
      n = 2 * th * f * tw * f + $urandom_range(0, 10);
      if (n > 400) n = 400;
      if (n > 1700 - items_sent) n = 1700 - items_sent;
      send_burst(n, 0);
      drain();
    end

    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
